// ----- rtl/dare_pkg.sv -----
// Shared constants and types for the dynamic array range engine.
package dare_pkg;
	localparam int Depth = 1024;
	localparam int WordWidth = 64;
	localparam int IdxW = $clog2(Depth);
	localparam int SizeW = 11;
	localparam int OpW = 3;

	localparam logic [OpW-1:0] OP_GET = 3'd0;
	localparam logic [OpW-1:0] OP_SET = 3'd1;
	localparam logic [OpW-1:0] OP_APPEND = 3'd2;
	localparam logic [OpW-1:0] OP_FILL = 3'd3;
	localparam logic [OpW-1:0] OP_DELETE = 3'd4;
	localparam logic [OpW-1:0] OP_INSERT = 3'd5;

	// Command from the sequencer to every cell of the row.
	typedef struct packed {
		logic                 shift_up;
		logic                 shift_down;
		logic                 wr_en;
		logic [WordWidth-1:0] wr_data;
		logic [IdxW-1:0]      lo;
		logic [IdxW-1:0]      hi;
	} cell_cmd_t;
endpackage

// ----- rtl/dare_cell.sv -----
// One storage cell of the array row; shifts with its neighbors or takes a write.
module dare_cell import dare_pkg::*; (
	input  logic                 clk,
	input  logic [IdxW-1:0]      my_idx,
	input  cell_cmd_t            cmd,
	input  logic [WordWidth-1:0] from_below,
	input  logic [WordWidth-1:0] from_above,
	output logic [WordWidth-1:0] word
);
	logic in_rng;
	logic [WordWidth-1:0] word_q;

	assign in_rng = (my_idx >= cmd.lo) && (my_idx <= cmd.hi);
	assign word = word_q;

	// Shift one place within the window, or take a direct write.
	always_ff @(posedge clk) begin
		if (cmd.shift_up && in_rng) begin
			word_q <= from_below;
		end else if (cmd.shift_down && in_rng) begin
			word_q <= from_above;
		end else if (cmd.wr_en && in_rng) begin
			word_q <= cmd.wr_data;
		end
	end
endmodule

// ----- rtl/dare_row.sv -----
// Row of cells with a registered read port.
module dare_row import dare_pkg::*; (
	input  logic                 clk,
	input  cell_cmd_t            cmd,
	input  logic [IdxW-1:0]      rd_idx,
	output logic [WordWidth-1:0] rd_data
);
	logic [WordWidth-1:0] words [Depth];
	logic [WordWidth-1:0] rd_q;

	for (genvar g = 0; g < Depth; g++) begin : g_cell
		logic [WordWidth-1:0] below, above;
		if (g == 0) begin : g_lo
			assign below = words[g];
		end else begin : g_lo_n
			assign below = words[g-1];
		end
		if (g == Depth - 1) begin : g_hi
			assign above = words[g];
		end else begin : g_hi_n
			assign above = words[g+1];
		end
		dare_cell u_cell (
			.clk       (clk),
			.my_idx    (IdxW'(g)),
			.cmd       (cmd),
			.from_below(below),
			.from_above(above),
			.word      (words[g])
		);
	end

	// Register the read word.
	always_ff @(posedge clk) begin
		rd_q <= words[rd_idx];
	end
	assign rd_data = rd_q;
endmodule

// ----- rtl/dynamic_array_range_engine.sv -----
// Top level: request sequencer driving the cell row.
// Usage:
//   Requests arrive on s_axis (tdata: opcode, position, count, value_in).
//   null_word is written on the cfg channel while the block is idle.
//   One result per request leaves on m_axis (tdata: read_value, array_size,
//   status). A result register parts the two sides.
// Steps, from the accepted request to the result: rejected requests, unused
//   opcodes and requests that change nothing go straight to the result step;
//   get reads through the registered read port; set, append, fill and an
//   insert at the end make one window write; delete shifts the window down
//   once per deleted word, and an insert inside the array shifts it up once
//   per inserted word before its write; a null gap write precedes the write.
// The row of cells moves one place per cycle; that shift sets the rate.
// One request is in work at a time; s_axis_tready drops while busy or
//   while a result waits to be taken, so the next request is accepted no
//   earlier than the cycle after the result is taken.
// Reset clears size, null word and control; the store content is undefined
//   until written. A stalled receiver holds the result and blocks input.
module dynamic_array_range_engine import dare_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [63:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // opcode[2:0], position[13:3], count[24:14], value_in[88:25]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata   // read_value[63:0], array_size[74:64], status[75]
);
	typedef enum logic [2:0] {ST_IDLE, ST_GAP, ST_SHIFT, ST_WRITE, ST_READ, ST_DONE} state_t;

	state_t state_q;
	logic [WordWidth-1:0] null_q, val_q, rd_w;
	logic [SizeW-1:0] size_q, pos_q, cnt_q, left_q, nsize_q;
	logic [OpW-1:0] op_q;
	logic up_q, st_q;
	logic m_valid_q;
	logic [WordWidth-1:0] m_rd_q;
	logic [SizeW-1:0] m_size_q;
	logic m_st_q;
	cell_cmd_t cmd;

	logic [OpW-1:0] i_op;
	logic [SizeW-1:0] i_pos, i_cnt;
	logic [SizeW+1:0] i_end, i_base;
	assign i_op = s_axis_tdata[2:0];
	assign i_pos = s_axis_tdata[13:3];
	assign i_cnt = s_axis_tdata[24:14];

	assign cfg_ready = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE) && !m_valid_q;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata = {4'b0, m_st_q, m_size_q, m_rd_q};

	assign i_end = (SizeW+2)'(i_pos) + (SizeW+2)'(i_cnt);
	assign i_base = (i_pos > size_q) ? (SizeW+2)'(i_pos) : (SizeW+2)'(size_q);

	// Drive the row from the current step.
	always_comb begin
		cmd = '0;
		cmd.wr_data = val_q;
		unique case (state_q)
			ST_GAP: begin
				cmd.wr_en = 1'b1;
				cmd.wr_data = null_q;
				cmd.lo = IdxW'(size_q);
				cmd.hi = IdxW'(pos_q - 11'd1);
			end
			ST_SHIFT: begin
				cmd.lo = IdxW'(pos_q);
				if (up_q) begin
					cmd.shift_up = 1'b1;
					cmd.lo = IdxW'(pos_q + 11'd1);
					cmd.hi = IdxW'(nsize_q - left_q);
				end else begin
					cmd.shift_down = 1'b1;
					cmd.hi = IdxW'(size_q - 11'd2);
				end
			end
			ST_WRITE: begin
				cmd.wr_en = 1'b1;
				cmd.lo = IdxW'(pos_q);
				cmd.hi = IdxW'(pos_q + cnt_q - 11'd1);
			end
			default: ;
		endcase
	end

	dare_row u_row (.clk(clk), .cmd(cmd), .rd_idx(IdxW'(pos_q)), .rd_data(rd_w));

	// Sequence requests and hold the result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			size_q <= '0;
			null_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) null_q <= cfg_data[WordWidth-1:0];
			if (m_valid_q && m_axis_tready) m_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						op_q <= i_op;
						pos_q <= i_pos;
						cnt_q <= i_cnt;
						val_q <= s_axis_tdata[88:25];
						st_q <= 1'b0;
						up_q <= 1'b0;
						state_q <= ST_DONE;
						unique case (i_op)
							OP_GET: state_q <= ST_READ;
							OP_SET: begin
								if (i_pos >= SizeW'(Depth)) st_q <= 1'b1;
								else begin
									cnt_q <= 11'd1;
									nsize_q <= (i_pos >= size_q) ? i_pos + 11'd1 : size_q;
									state_q <= (i_pos > size_q) ? ST_GAP : ST_WRITE;
								end
							end
							OP_APPEND: begin
								if (size_q >= SizeW'(Depth)) st_q <= 1'b1;
								else begin
									pos_q <= size_q;
									cnt_q <= 11'd1;
									nsize_q <= size_q + 11'd1;
									state_q <= ST_WRITE;
								end
							end
							OP_FILL: begin
								if (i_end > (SizeW+2)'(Depth)) st_q <= 1'b1;
								else begin
									nsize_q <= (i_end > (SizeW+2)'(size_q)) ?
										SizeW'(i_end) : size_q;
									state_q <= (i_pos > size_q) ? ST_GAP :
										(i_cnt != 0) ? ST_WRITE : ST_DONE;
								end
							end
							OP_DELETE: begin
								if (i_pos < size_q) begin
									cnt_q <= (i_cnt > size_q - i_pos) ? size_q - i_pos : i_cnt;
									left_q <= (i_cnt > size_q - i_pos) ? size_q - i_pos : i_cnt;
									state_q <= (i_cnt != 0) ? ST_SHIFT : ST_DONE;
								end
							end
							OP_INSERT: begin
								if (i_base + (SizeW+2)'(i_cnt) > (SizeW+2)'(Depth)) st_q <= 1'b1;
								else begin
									nsize_q <= SizeW'(i_base + (SizeW+2)'(i_cnt));
									left_q <= i_cnt;
									up_q <= 1'b1;
									state_q <= (i_pos > size_q) ? ST_GAP :
										(i_cnt == 0) ? ST_DONE :
										(i_pos < size_q) ? ST_SHIFT : ST_WRITE;
								end
							end
							default: ;
						endcase
					end
				end
				ST_GAP: begin
					size_q <= (cnt_q != 0) ? pos_q : nsize_q;
					state_q <= (cnt_q != 0) ? ST_WRITE : ST_DONE;
				end
				ST_SHIFT: begin
					// Insert grows by one a step; delete shrinks by one a step.
					left_q <= left_q - 11'd1;
					if (up_q) size_q <= size_q + 11'd1;
					else size_q <= size_q - 11'd1;
					if (left_q == 11'd1) state_q <= up_q ? ST_WRITE : ST_DONE;
				end
				ST_WRITE: begin
					size_q <= nsize_q;
					state_q <= ST_DONE;
				end
				ST_READ: state_q <= ST_DONE;
				ST_DONE: begin
					m_valid_q <= 1'b1;
					m_size_q <= size_q;
					m_st_q <= st_q;
					m_rd_q <= (op_q == OP_GET && pos_q < size_q) ? rd_w : null_q;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Size never exceeds capacity.
	a_size: assert property (@(posedge clk) disable iff (!arst_n) size_q <= SizeW'(Depth))
		else $error("size over capacity");
	// No new request while a result waits.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n) m_valid_q |-> !s_axis_tready)
		else $error("ready while result pending");
	// A result follows the done step.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> m_valid_q)
		else $error("result lost");
endmodule

// ----- tb/testbench.sv -----
// Testbench for the dynamic array range engine: directed table plus random requests.
`timescale 1ns / 1ps

module testbench;
	import dare_pkg::*;

	localparam int LIMIT_CYCLES = 3000000;

	typedef struct {
		logic [OpW-1:0]       op;
		logic [SizeW-1:0]     pos;
		logic [SizeW-1:0]     cnt;
		logic [WordWidth-1:0] val;
		bit                   typed;
		logic [WordWidth-1:0] x_rd;
		logic [SizeW-1:0]     x_size;
		logic                 x_st;
	} req_row_t;

	typedef struct {
		logic [WordWidth-1:0] rd;
		logic [SizeW-1:0]     size;
		logic                 st;
	} answer_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [63:0] cfg_data;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [95:0] s_axis_tdata;   // opcode, position, count, value_in
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [79:0] m_axis_tdata;   // read_value, array_size, status

	// Predictor state
	logic [WordWidth-1:0] shadow_words [Depth];
	int unsigned shadow_size;
	logic [WordWidth-1:0] shadow_null;

	answer_t answers_due [$];
	int errors;
	int cycles;
	bit sending_done;

	dynamic_array_range_engine dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Fill entries from the current end up to a limit with the null word
	function automatic void pad_gap(int unsigned upto);
		for (int unsigned i = shadow_size; i < upto; i++) shadow_words[i] = shadow_null;
	endfunction

	// Apply one request to the shadow array and return its answer
	function automatic answer_t apply_request(logic [OpW-1:0] op, int unsigned pos,
			int unsigned cnt, logic [WordWidth-1:0] val);
		answer_t a;
		int unsigned base;
		int unsigned newsize;
		a.rd = shadow_null;
		a.st = 1'b0;
		case (op)
			OP_GET: begin
				if (pos < shadow_size) a.rd = shadow_words[pos];
			end
			OP_SET: begin
				if (pos + 1 > Depth) a.st = 1'b1;
				else begin
					pad_gap(pos);
					shadow_words[pos] = val;
					if (pos + 1 > shadow_size) shadow_size = pos + 1;
				end
			end
			OP_APPEND: begin
				if (shadow_size + 1 > Depth) a.st = 1'b1;
				else begin
					shadow_words[shadow_size] = val;
					shadow_size++;
				end
			end
			OP_FILL: begin
				if (pos + cnt > Depth) a.st = 1'b1;
				else begin
					pad_gap(pos);
					for (int unsigned i = pos; i < pos + cnt; i++) shadow_words[i] = val;
					if (pos + cnt > shadow_size) shadow_size = pos + cnt;
				end
			end
			OP_DELETE: begin
				if (pos < shadow_size) begin
					if (cnt > shadow_size - pos) cnt = shadow_size - pos;
					for (int unsigned i = pos; i + cnt < shadow_size; i++)
						shadow_words[i] = shadow_words[i + cnt];
					shadow_size -= cnt;
				end
			end
			OP_INSERT: begin
				base = (pos > shadow_size) ? pos : shadow_size;
				newsize = base + cnt;
				if (newsize > Depth) a.st = 1'b1;
				else begin
					if (pos < shadow_size) begin
						for (int unsigned i = shadow_size; i > pos; i--)
							shadow_words[i - 1 + cnt] = shadow_words[i - 1];
					end else begin
						pad_gap(pos);
					end
					for (int unsigned i = pos; i < pos + cnt; i++) shadow_words[i] = val;
					shadow_size = newsize;
				end
			end
			default: ;
		endcase
		a.size = shadow_size[SizeW-1:0];
		return a;
	endfunction

	// Directed requests; typed rows carry the answer read off directly
	req_row_t directed [] = '{
		'{OP_GET,    11'd0,    11'd0,    64'h0,                 1, 64'h0, 11'd0,    1'b0},
		'{OP_GET,    11'd2047, 11'd2047, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'h0, 11'd0,  1'b0},
		'{OP_SET,    11'd1024, 11'd0,    64'h1,                 1, 64'h0, 11'd0,    1'b1},
		'{OP_SET,    11'd2047, 11'd0,    64'h1,                 1, 64'h0, 11'd0,    1'b1},
		'{OP_FILL,   11'd1,    11'd1024, 64'h2,                 1, 64'h0, 11'd0,    1'b1},
		'{OP_FILL,   11'd2047, 11'd2047, 64'h2,                 1, 64'h0, 11'd0,    1'b1},
		'{OP_INSERT, 11'd1000, 11'd100,  64'h3,                 1, 64'h0, 11'd0,    1'b1},
		'{OP_DELETE, 11'd0,    11'd5,    64'h0,                 1, 64'h0, 11'd0,    1'b0},
		'{3'd6,      11'd5,    11'd5,    64'h5,                 1, 64'h0, 11'd0,    1'b0},
		'{3'd7,      11'd5,    11'd5,    64'h5,                 1, 64'h0, 11'd0,    1'b0},
		'{OP_APPEND, 11'd2047, 11'd2047, 64'hFFFF_FFFF_FFFF_FFFF, 1, 64'h0, 11'd1, 1'b0},
		'{OP_SET,    11'd4,    11'd0,    64'hA5A5,              0, 64'h0, 11'd0,    1'b0},
		'{OP_GET,    11'd2,    11'd0,    64'h0,                 0, 64'h0, 11'd0,    1'b0},
		'{OP_FILL,   11'd8,    11'd0,    64'h7,                 0, 64'h0, 11'd0,    1'b0},
		'{OP_FILL,   11'd8,    11'd3,    64'h7,                 0, 64'h0, 11'd0,    1'b0},
		'{OP_INSERT, 11'd2,    11'd3,    64'hBEEF,              0, 64'h0, 11'd0,    1'b0},
		'{OP_INSERT, 11'd20,   11'd2,    64'hCAFE,              0, 64'h0, 11'd0,    1'b0},
		'{OP_DELETE, 11'd50,   11'd2,    64'h0,                 0, 64'h0, 11'd0,    1'b0},
		'{OP_DELETE, 11'd3,    11'd2047, 64'h0,                 0, 64'h0, 11'd0,    1'b0},
		'{OP_FILL,   11'd0,    11'd1024, 64'h5555,              0, 64'h0, 11'd0,    1'b0},
		'{OP_APPEND, 11'd0,    11'd0,    64'h9,                 0, 64'h0, 11'd0,    1'b0},
		'{OP_INSERT, 11'd0,    11'd0,    64'h9,                 0, 64'h0, 11'd0,    1'b0},
		'{OP_GET,    11'd1023, 11'd0,    64'h0,                 0, 64'h0, 11'd0,    1'b0},
		'{OP_DELETE, 11'd0,    11'd1024, 64'h0,                 0, 64'h0, 11'd0,    1'b0}
	};

	// Send one request and record its answer; valid stays high when no idle follows
	task automatic send_request(logic [OpW-1:0] op, logic [SizeW-1:0] pos,
			logic [SizeW-1:0] cnt, logic [WordWidth-1:0] val, bit typed, answer_t typed_ans);
		answer_t a;
		int gap;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata <= {7'd0, val, cnt, pos, op};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		a = apply_request(op, pos, cnt, val);
		if (typed && (a.rd !== typed_ans.rd || a.size !== typed_ans.size ||
				a.st !== typed_ans.st)) begin
			$display("%0t typed answer disagrees with predictor: exp %h/%0d/%0d pred %h/%0d/%0d",
				$time, typed_ans.rd, typed_ans.size, typed_ans.st, a.rd, a.size, a.st);
			errors++;
		end
		answers_due.push_back(typed ? typed_ans : a);
	endtask

	// Write the null word once every answer is in and the block has settled
	task automatic write_null(logic [63:0] w);
		s_axis_tvalid <= 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
		repeat (1100) @(posedge clk);
		cfg_data <= w;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		shadow_null = w;
	endtask

	// Random request, mostly valid and small sized
	task automatic send_random();
		logic [OpW-1:0] op;
		int unsigned pos;
		int unsigned cnt;
		int sel;
		sel = $urandom_range(0, 99);
		op = (sel < 95) ? OpW'($urandom_range(0, 5)) : OpW'($urandom_range(6, 7));
		case ($urandom_range(0, 9))
			0: pos = $urandom_range(0, 2047);
			1: pos = $urandom_range(1000, 1024);
			default: pos = $urandom_range(0, shadow_size + 4);
		endcase
		case ($urandom_range(0, 9))
			0: cnt = $urandom_range(0, 2047);
			1: cnt = $urandom_range(0, 300);
			default: cnt = $urandom_range(0, 8);
		endcase
		// keep the array from sitting full for long
		if (shadow_size > 900 && $urandom_range(0, 1)) begin
			op = OP_DELETE;
			cnt = $urandom_range(100, 900);
		end
		send_request(op, pos[SizeW-1:0], cnt[SizeW-1:0], {$urandom, $urandom}, 0, '{0, 0, 0});
	endtask

	// Stimulus
	initial begin
		answer_t t;
		errors = 0;
		sending_done = 0;
		shadow_size = 0;
		shadow_null = '0;
		cfg_valid = 0;
		cfg_data = '0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		arst_n = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (directed[i]) begin
			t.rd = directed[i].x_rd;
			t.size = directed[i].x_size;
			t.st = directed[i].x_st;
			send_request(directed[i].op, directed[i].pos, directed[i].cnt,
				directed[i].val, directed[i].typed, t);
		end
		write_null(64'hFFFF_FFFF_FFFF_FFFF);
		for (int k = 0; k < 200; k++) send_random();
		write_null({$urandom, $urandom});
		for (int k = 0; k < 200; k++) send_random();
		write_null(64'h0);
		for (int k = 0; k < 200; k++) send_random();
		s_axis_tvalid <= 1'b0;
		sending_done = 1;
	end

	// Receiver: wait a drawn number of cycles per result, then take it
	initial begin
		int stall;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (m_axis_tvalid) begin
				stall = $urandom_range(0, 7);
				repeat (stall) @(posedge clk);
				m_axis_tready <= 1'b1;
				@(posedge clk);
				while (!m_axis_tvalid) @(posedge clk);
				m_axis_tready <= 1'b0;
			end
		end
	end

	// Compare each result transaction with the oldest answer due
	always @(posedge clk) begin
		answer_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (answers_due.size() == 0) begin
				$display("%0t unexpected result: actual %h", $time, m_axis_tdata);
				errors++;
			end else begin
				e = answers_due.pop_front();
				if (m_axis_tdata[63:0] !== e.rd) begin
					$display("%0t read_value: exp %h act %h", $time, e.rd, m_axis_tdata[63:0]);
					errors++;
				end
				if (m_axis_tdata[74:64] !== e.size) begin
					$display("%0t array_size: exp %0d act %0d", $time, e.size, m_axis_tdata[74:64]);
					errors++;
				end
				if (m_axis_tdata[75] !== e.st) begin
					$display("%0t status: exp %0d act %0d", $time, e.st, m_axis_tdata[75]);
					errors++;
				end
			end
		end
	end

	// End of run and timeout
	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > LIMIT_CYCLES) begin
				$display("Mismatches found");
				$finish;
			end
			if (sending_done && answers_due.size() == 0) begin
				repeat (1100) @(posedge clk);
				if (errors == 0 && answers_due.size() == 0) begin
					$display("No mismatches found");
				end else begin
					$display("Mismatches found");
				end
				$finish;
			end
		end
	end
endmodule

// ----- filelist.f -----
rtl/dare_pkg.sv
rtl/dare_cell.sv
rtl/dare_row.sv
rtl/dynamic_array_range_engine.sv
tb/testbench.sv
